/* hw/rtl/owm_pkg.sv */
// Shared types, constants and register map for the 1-Wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int NUM_CFG       = 8;
    localparam int CFG_IDX_W     = $clog2(NUM_CFG);
    localparam int TICK_W        = 16;
    localparam int APB_ADDR_W    = CFG_IDX_W + 2;
    localparam int APB_DATA_W    = 32;
    localparam int S_TDATA_W     = 16;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 16;

    typedef logic [TICK_W-1:0]               tick_t;
    typedef logic [NUM_CFG-1:0][TICK_W-1:0]  cfg_array_t;
    typedef logic [CFG_IDX_W-1:0]            cfg_idx_t;
    typedef logic [BIT_IDX_W-1:0]            bit_idx_t;

    localparam cfg_idx_t REG_RESET_LOW     = 3'd0;
    localparam cfg_idx_t REG_PRESENCE_WAIT = 3'd1;
    localparam cfg_idx_t REG_RESET_TAIL    = 3'd2;
    localparam cfg_idx_t REG_WRITE_START   = 3'd3;
    localparam cfg_idx_t REG_WRITE_HOLD    = 3'd4;
    localparam cfg_idx_t REG_READ_START    = 3'd5;
    localparam cfg_idx_t REG_READ_SAMPLE   = 3'd6;
    localparam cfg_idx_t REG_READ_TAIL     = 3'd7;

    // index 7 down to index 0
    localparam cfg_array_t CFG_RESET = {
        16'd50, 16'd5, 16'd5, 16'd50, 16'd10, 16'd500, 16'd70, 16'd500
    };

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_WBYTE = 3'd2,
        CMD_RBYTE = 3'd3,
        CMD_WBIT  = 3'd4,
        CMD_RBIT  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic       cmd_valid;
        cmd_t       kind;
        logic [7:0] tx;
        logic       line;
    } item_t;

    typedef struct packed {
        logic       presence_level;
        logic [7:0] rx_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

endpackage

/* hw/rtl/owm_regs.sv */
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module owm_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [owm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [owm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [owm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output owm_pkg::cfg_array_t                 cfg
);

    owm_pkg::cfg_array_t cfg_reg;
    owm_pkg::cfg_idx_t   idx;
    logic                wr_en;

    assign idx    = paddr[owm_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(owm_pkg::APB_DATA_W - owm_pkg::TICK_W){1'b0}}, cfg_reg[idx]};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= owm_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            cfg_reg[idx] <= pwdata[owm_pkg::TICK_W-1:0];
        end
    end

endmodule

/* hw/rtl/owm_front.sv */
// Front end: decodes incoming tick transactions into queue entries.
`timescale 1ns / 1ps

module owm_front
(
    input  logic [owm_pkg::S_TUSER_W-1:0]  req_type,
    input  logic [7:0]                     tx_data,
    input  logic                           line_in,
    output owm_pkg::item_t                 item
);

    always_comb
    begin
        item.line      = line_in;
        item.tx        = tx_data;
        item.cmd_valid = 1'b1;
        item.kind      = owm_pkg::CMD_NONE;
        case (req_type)
            owm_pkg::CMD_RESET: item.kind = owm_pkg::CMD_RESET;
            owm_pkg::CMD_WBYTE: item.kind = owm_pkg::CMD_WBYTE;
            owm_pkg::CMD_RBYTE: item.kind = owm_pkg::CMD_RBYTE;
            owm_pkg::CMD_WBIT:
            begin
                item.kind = owm_pkg::CMD_WBIT;
                item.tx   = {7'd0, tx_data[0]};
            end
            owm_pkg::CMD_RBIT:  item.kind = owm_pkg::CMD_RBIT;
            default:            item.cmd_valid = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/owm_queue.sv */
// Two-entry queue between front end and slot sequencer.
`timescale 1ns / 1ps

module owm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  owm_pkg::item_t  push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output owm_pkg::item_t  head
);

    owm_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/owm_back.sv */
// Back end: 1-Wire slot sequencer, one tick per queue entry, with output register.
`timescale 1ns / 1ps

module owm_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  owm_pkg::cfg_array_t  cfg,
    input  logic                 q_valid,
    input  owm_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output owm_pkg::res_t        out_res
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_TAIL  = 4'd3,
        PH_WR_START  = 4'd4,
        PH_WR_HOLD   = 4'd5,
        PH_RD_START  = 4'd6,
        PH_RD_SAMPLE = 4'd7,
        PH_RD_TAIL   = 4'd8
    } phase_t;

    phase_t              phase_reg, phase_next;
    owm_pkg::tick_t      tick_count_reg, tick_count_next;
    owm_pkg::bit_idx_t   bit_index_reg, bit_index_next;
    logic [7:0]          shift_out_reg, shift_out_next;
    logic [7:0]          shift_in_reg, shift_in_next;
    owm_pkg::cmd_t       kind_reg, kind_next;
    logic                presence_reg, presence_next;
    logic                out_valid_reg;
    owm_pkg::res_t       out_res_reg;
    owm_pkg::res_t       res_next;

    owm_pkg::tick_t      limit;
    logic                last;
    logic                more_bits;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        kind_next       = kind_reg;
        presence_next   = presence_reg;
        res_next        = '0;

        // command taken only when idle
        if (phase_reg == PH_IDLE && q_item.cmd_valid)
        begin
            kind_next       = q_item.kind;
            tick_count_next = '0;
            bit_index_next  = '0;
            case (q_item.kind)
                owm_pkg::CMD_RESET: phase_next = PH_RST_LOW;
                owm_pkg::CMD_WBYTE,
                owm_pkg::CMD_WBIT:
                begin
                    shift_out_next = q_item.tx;
                    phase_next     = PH_WR_START;
                end
                default:
                begin
                    shift_in_next = '0;
                    phase_next    = PH_RD_START;
                end
            endcase
        end

        case (phase_next)
            PH_RST_LOW:   limit = cfg[owm_pkg::REG_RESET_LOW];
            PH_RST_WAIT:  limit = cfg[owm_pkg::REG_PRESENCE_WAIT];
            PH_RST_TAIL:  limit = cfg[owm_pkg::REG_RESET_TAIL];
            PH_WR_START:  limit = cfg[owm_pkg::REG_WRITE_START];
            PH_WR_HOLD:   limit = cfg[owm_pkg::REG_WRITE_HOLD];
            PH_RD_START:  limit = cfg[owm_pkg::REG_READ_START];
            PH_RD_SAMPLE: limit = cfg[owm_pkg::REG_READ_SAMPLE];
            PH_RD_TAIL:   limit = cfg[owm_pkg::REG_READ_TAIL];
            default:      limit = owm_pkg::tick_t'(1);
        endcase

        last = ({1'b0, tick_count_next} + 17'd1) >= {1'b0, limit};
        more_bits = (kind_next == owm_pkg::CMD_WBYTE || kind_next == owm_pkg::CMD_RBYTE)
                    && (({1'b0, bit_index_next} + 4'd1) < 4'(owm_pkg::BITS_PER_BYTE));

        if (phase_next != PH_IDLE)
        begin
            res_next.busy_res = 1'b1;
            case (phase_next)
                PH_RST_LOW,
                PH_WR_START,
                PH_RD_START: res_next.drive_low = 1'b1;
                PH_WR_HOLD:  res_next.drive_low = ~shift_out_next[bit_index_next];
                default:     res_next.drive_low = 1'b0;
            endcase

            if (!last)
            begin
                tick_count_next = tick_count_next + owm_pkg::tick_t'(1);
            end
            else
            begin
                tick_count_next = '0;
                case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = q_item.line;
                        phase_next    = PH_RST_TAIL;
                    end
                    PH_WR_START: phase_next = PH_WR_HOLD;
                    PH_RD_START: phase_next = PH_RD_SAMPLE;
                    PH_RD_SAMPLE:
                    begin
                        if (q_item.line)
                        begin
                            shift_in_next[bit_index_next] = 1'b1;
                        end
                        phase_next = PH_RD_TAIL;
                    end
                    PH_WR_HOLD,
                    PH_RD_TAIL:
                    begin
                        if (more_bits)
                        begin
                            phase_next     = (phase_next == PH_WR_HOLD) ? PH_WR_START
                                                                        : PH_RD_START;
                            bit_index_next = bit_index_next + owm_pkg::bit_idx_t'(1);
                        end
                        else
                        begin
                            res_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        res_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                endcase
            end
        end

        res_next.rx_data        = shift_in_next;
        res_next.presence_level = presence_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            kind_reg       <= owm_pkg::CMD_NONE;
            presence_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                shift_out_reg  <= shift_out_next;
                shift_in_reg   <= shift_in_next;
                kind_reg       <= kind_next;
                presence_reg   <= presence_next;
                out_res_reg    <= res_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/onewire_bus_master_top.sv */
// Top level of the tick-driven 1-Wire bus master.
//
// Each slave-side transaction is one tick of the timebase: tdata carries the
// byte to send and the sampled bus level, tuser the command code (0 tick only,
// 1 reset, 2 write byte, 3 read byte, 4 write bit, 5 read bit). A command is
// taken only on a tick where the sequencer is idle; otherwise it is ignored.
// Every tick yields exactly one master-side transaction carrying the bus drive,
// busy, done, receive register and presence level for that tick.
// Ticks are decoded into a two-entry queue and executed by the slot sequencer,
// one tick per cycle unless the master side stalls, into an output register. An
// accepted tick is registered in a queue entry and then in the output register.
// When the master side stalls, the output register holds, the queue fills and
// s_axis_tready falls after at most two more ticks; nothing is dropped.
// Reset empties the queue and output, returns the sequencer to idle with
// presence level 1 and loads the default slot timings. Timing registers are
// written over the APB port at byte address 4*index; idle-only writes are the user's duty.
`timescale 1ns / 1ps

module onewire_bus_master_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [owm_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // tx_data[7:0], line_in, zero pad
    input  logic [owm_pkg::S_TUSER_W-1:0]       s_axis_tuser,  // req_type[2:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [owm_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // drive_low, busy_res, done_res,
                                                               // rx_data[7:0], presence_level, pad
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [owm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [owm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [owm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    owm_pkg::cfg_array_t cfg;
    owm_pkg::item_t      front_item;
    owm_pkg::item_t      q_head;
    owm_pkg::res_t       res;
    logic                q_not_full;
    logic                q_not_empty;
    logic                q_pop;

    assign s_axis_tready = q_not_full;
    assign m_axis_tdata  = {{(owm_pkg::M_TDATA_W - $bits(owm_pkg::res_t)){1'b0}}, res};

    owm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_front u_front
    (
        .req_type (s_axis_tuser),
        .tx_data  (s_axis_tdata[7:0]),
        .line_in  (s_axis_tdata[8]),
        .item     (front_item)
    );

    owm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    owm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_not_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

endmodule
